FILE: rtl/core/tbpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpc_pkg
// Shared types, register indexes and constants of the touch button press
// classifier.
// ----------------------------------------------------------------------------
package tbpc_pkg;

    // Fixed field widths
    localparam int PAD_W     = 4;
    localparam int VALUE_W   = 16;
    localparam int TIME_W    = 32;
    localparam int PCT_W     = 8;
    localparam int LEVEL_W   = 2;
    localparam int MASK_BITS = 10;
    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Item modes
    localparam logic MODE_SAMPLE    = 1'b0;
    localparam logic MODE_CALIBRATE = 1'b1;

    // Divide by 100 through a reciprocal: m = ceil(2^31 / 100)
    localparam int RECIP_SHIFT = 31;
    localparam int SCALE_W     = 33;
    localparam logic [SCALE_W-1:0] PCT_RECIP = 33'd21474837;
    localparam int PROD_W      = VALUE_W + SCALE_W;
    localparam int QUOT_W      = 18;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE_MASK = 3'd0,
        REG_FALL_MASK   = 3'd1,
        REG_SHORT_TIME  = 3'd2,
        REG_MEDIUM_TIME = 3'd3,
        REG_LONG_TIME   = 3'd4
    } cfg_idx_t;

    // Stored press level
    typedef enum logic [LEVEL_W-1:0] {
        LVL_NONE   = 2'd0,
        LVL_SHORT  = 2'd1,
        LVL_MEDIUM = 2'd2,
        LVL_LONG   = 2'd3
    } level_t;

    typedef struct packed {
        logic [MASK_BITS-1:0] enable_mask;
        logic [MASK_BITS-1:0] fall_mask;
        logic [LIMIT_W-1:0]   short_time;
        logic [LIMIT_W-1:0]   medium_time;
        logic [LIMIT_W-1:0]   long_time;
    } cfg_t;

    typedef struct packed {
        logic               mode;
        logic [PAD_W-1:0]   pad_index;
        logic [VALUE_W-1:0] sense_value;
        logic [TIME_W-1:0]  time_ms;
        logic [PCT_W-1:0]   percent;
    } item_t;

    typedef struct packed {
        logic               event_valid;
        logic [PAD_W-1:0]   event_pad;
        logic [LEVEL_W-1:0] event_level;
        logic               event_on_release;
        logic               pressed_now;
    } result_t;

    // Per-percent reciprocal scale, a constant table of pct * m
    function automatic logic [SCALE_W-1:0] pct_scale(input logic [PCT_W-1:0] pct);
        pct_scale = SCALE_W'(pct) * PCT_RECIP;
    endfunction

    // Mask bit of a pad; pads past the mask width read as zero
    function automatic logic mask_bit(input logic [MASK_BITS-1:0] mask,
                                      input logic [PAD_W-1:0] pad);
        logic bit_val;
        bit_val = 1'b0;
        if (pad < PAD_W'(MASK_BITS))
        begin
            bit_val = mask[pad];
        end
        mask_bit = bit_val;
    endfunction

endpackage

FILE: rtl/core/touch_button_press_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_button_press_classifier
// Classifies capacitive pad samples into short, medium and long presses and
// calibrates pad thresholds.
// ----------------------------------------------------------------------------
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  input    | in_valid/in_ready, mode, pad_index, sense_value, | in
//           | time_ms, percent                                |
//  result   | out_valid/out_ready, event_valid, event_pad,     | out
//           | event_level, event_on_release, pressed_now      |
//  config   | cfg_we, cfg_index, cfg_data                     | in
//
//  One item per cycle unless out_ready stalls; input then result register.
//  The pad lookup, hold-time compare and state write all sit in the stage
//  between the two registers, so back-to-back items on one pad see fresh state.
//  Reset clears all pad state and loads the default limits; no clearing pass.
//  A stalled result register holds the item in the input register; in_ready
//  drops only when both registers are full and out_ready is low.
// ----------------------------------------------------------------------------
module touch_button_press_classifier #(
    parameter int PAD_COUNT = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic [tbpc_pkg::PAD_W-1:0]      pad_index,
    input  logic [tbpc_pkg::VALUE_W-1:0]    sense_value,
    input  logic [tbpc_pkg::TIME_W-1:0]     time_ms,
    input  logic [tbpc_pkg::PCT_W-1:0]      percent,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            event_valid,
    output logic [tbpc_pkg::PAD_W-1:0]      event_pad,
    output logic [tbpc_pkg::LEVEL_W-1:0]    event_level,
    output logic                            event_on_release,
    output logic                            pressed_now,
    // configuration
    input  logic                            cfg_we,
    input  logic [tbpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbpc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tbpc_pkg::*;

    logic    s1_valid_reg;
    logic    s1_valid_next;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;

    logic               advance;
    logic               in_xfer;
    cfg_t               cfg;
    logic [VALUE_W-1:0] new_threshold;
    result_t            result;

    // Handshake control
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_item_reg.mode        <= mode;
            s1_item_reg.pad_index   <= pad_index;
            s1_item_reg.sense_value <= sense_value;
            s1_item_reg.time_ms     <= time_ms;
            s1_item_reg.percent     <= percent;
        end
        if (advance)
        begin
            out_res_reg <= result;
        end
    end

    tbpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tbpc_threshold_calc u_threshold_calc (
        .sense_value (s1_item_reg.sense_value),
        .percent     (s1_item_reg.percent),
        .threshold   (new_threshold)
    );

    tbpc_pad_engine #(
        .PAD_COUNT (PAD_COUNT)
    ) u_pad_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (s1_item_reg),
        .commit        (advance),
        .cfg           (cfg),
        .new_threshold (new_threshold),
        .result        (result)
    );

    assign out_valid        = out_valid_reg;
    assign event_valid      = out_res_reg.event_valid;
    assign event_pad        = out_res_reg.event_pad;
    assign event_level      = out_res_reg.event_level;
    assign event_on_release = out_res_reg.event_on_release;
    assign pressed_now      = out_res_reg.pressed_now;

endmodule

FILE: rtl/core/tbpc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpc_cfg_regs
// Configuration register file: pad masks and the three hold-time limits.
// ----------------------------------------------------------------------------
module tbpc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tbpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbpc_pkg::CFG_DATA_W-1:0] cfg_data,
    output tbpc_pkg::cfg_t                cfg
);
    import tbpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE_MASK: cfg_next.enable_mask = cfg_data[MASK_BITS-1:0];
                REG_FALL_MASK:   cfg_next.fall_mask   = cfg_data[MASK_BITS-1:0];
                REG_SHORT_TIME:  cfg_next.short_time  = cfg_data[LIMIT_W-1:0];
                REG_MEDIUM_TIME: cfg_next.medium_time = cfg_data[LIMIT_W-1:0];
                REG_LONG_TIME:   cfg_next.long_time   = cfg_data[LIMIT_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_mask <= '0;
            cfg_reg.fall_mask   <= '0;
            cfg_reg.short_time  <= 16'd50;
            cfg_reg.medium_time <= 16'd500;
            cfg_reg.long_time   <= 16'd2000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/tbpc_threshold_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpc_threshold_calc
// Calibration threshold: value * percent / 100, saturated to 16 bits.
// ----------------------------------------------------------------------------
module tbpc_threshold_calc (
    input  logic [tbpc_pkg::VALUE_W-1:0] sense_value,
    input  logic [tbpc_pkg::PCT_W-1:0]   percent,
    output logic [tbpc_pkg::VALUE_W-1:0] threshold
);
    import tbpc_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot;

    // One multiply by the per-percent reciprocal; exact for 24-bit products
    assign prod = PROD_W'(sense_value) * PROD_W'(pct_scale(percent));
    assign quot = prod[RECIP_SHIFT +: QUOT_W];

    // Saturate to the threshold width
    assign threshold = (quot[QUOT_W-1:VALUE_W] != '0) ? '1 : quot[VALUE_W-1:0];

endmodule

FILE: rtl/core/tbpc_pad_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbpc_pad_engine
// Per-pad state and the press classifier for the item in the input register.
// ----------------------------------------------------------------------------
module tbpc_pad_engine #(
    parameter int PAD_COUNT = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tbpc_pkg::item_t              item,
    input  logic                         commit,
    input  tbpc_pkg::cfg_t               cfg,
    input  logic [tbpc_pkg::VALUE_W-1:0] new_threshold,
    output tbpc_pkg::result_t            result
);
    import tbpc_pkg::*;

    localparam int IDX_W = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    logic [VALUE_W-1:0] thr_reg     [PAD_COUNT];
    logic               pressed_reg [PAD_COUNT];
    logic [TIME_W-1:0]  start_reg   [PAD_COUNT];
    level_t             level_reg   [PAD_COUNT];

    logic              in_range;
    logic [IDX_W-1:0]  idx;
    logic              enabled;
    logic              fall_mode;
    logic              is_cal;
    logic              pressed;
    logic              was_pressed;
    logic [TIME_W-1:0] held;
    level_t            last_lvl;
    level_t            new_lvl;
    logic              wr_thr;
    logic              wr_state;
    logic              wr_start;

    // Lookup of the addressed pad
    always_comb
    begin
        in_range    = (5'(item.pad_index) < 5'(PAD_COUNT));
        idx         = in_range ? item.pad_index[IDX_W-1:0] : '0;
        enabled     = in_range && mask_bit(cfg.enable_mask, item.pad_index);
        fall_mode   = mask_bit(cfg.fall_mask, item.pad_index);
        is_cal      = (item.mode == MODE_CALIBRATE);
        pressed     = item.sense_value < thr_reg[idx];
        was_pressed = pressed_reg[idx];
        last_lvl    = level_reg[idx];
        held        = item.time_ms - start_reg[idx];
    end

    // Level update: cleared when not pressed; else long, then medium, then short
    always_comb
    begin
        new_lvl  = last_lvl;
        wr_start = 1'b0;
        if (!pressed)
        begin
            new_lvl = LVL_NONE;
        end
        else if (!was_pressed)
        begin
            wr_start = 1'b1;
        end
        else if (held >= TIME_W'(cfg.long_time))
        begin
            new_lvl = LVL_LONG;
        end
        else if (held >= TIME_W'(cfg.medium_time))
        begin
            new_lvl = LVL_MEDIUM;
        end
        else if (held >= TIME_W'(cfg.short_time))
        begin
            new_lvl = LVL_SHORT;
        end
    end

    // Event and result fields
    always_comb
    begin
        result                  = '0;
        result.event_pad        = item.pad_index;
        result.pressed_now      = in_range && !is_cal && pressed;
        if (enabled && !is_cal)
        begin
            if (!fall_mode)
            begin
                if ((new_lvl != LVL_NONE) && (new_lvl != last_lvl))
                begin
                    result.event_valid = 1'b1;
                    result.event_level = new_lvl - 2'd1;
                end
            end
            else if ((new_lvl == LVL_NONE) && (last_lvl != LVL_NONE))
            begin
                result.event_valid      = 1'b1;
                result.event_level      = last_lvl - 2'd1;
                result.event_on_release = 1'b1;
            end
        end
    end

    assign wr_thr   = commit && enabled && is_cal;
    assign wr_state = commit && enabled && !is_cal;

    // Pad state storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PAD_COUNT; p++)
            begin
                thr_reg[p]     <= '0;
                pressed_reg[p] <= 1'b0;
                start_reg[p]   <= '0;
                level_reg[p]   <= LVL_NONE;
            end
        end
        else
        begin
            if (wr_thr)
            begin
                thr_reg[idx] <= new_threshold;
            end
            if (wr_state)
            begin
                pressed_reg[idx] <= pressed;
                level_reg[idx]   <= new_lvl;
                if (wr_start)
                begin
                    start_reg[idx] <= item.time_ms;
                end
            end
        end
    end

    // Checks
    a_release_is_event: assert property (@(posedge clk) disable iff (!rst_n)
        result.event_on_release |-> result.event_valid)
        else $error("release flag without event");

    a_event_needs_enabled_sample: assert property (@(posedge clk) disable iff (!rst_n)
        result.event_valid |-> (enabled && !is_cal))
        else $error("event from calibrate item or disabled pad");

    a_release_not_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        result.event_on_release |-> !result.pressed_now)
        else $error("release event while pad pressed");

    a_threshold_written: assert property (@(posedge clk) disable iff (!rst_n)
        wr_thr |=> (thr_reg[$past(idx)] == $past(new_threshold)))
        else $error("calibrated threshold not stored");

endmodule
